/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes for the two-wire bus master bit engine
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int TPU_W  = 16;
	localparam int WAIT_W = 20;

	// command codes
	localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE_ACK = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_ACK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_NACK = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD      = 3'd7;

	localparam logic [TPU_W-1:0] TPU_RESET = 16'd100;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] write_data;
		logic              sda_in;
	} i2cm_item_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] read_data;
		logic              ack;
	} i2cm_res_t;

endpackage

`default_nettype wire

/* rtl/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// i2cm_seq
// bus sequencer state and result register, one word per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire i2cm_pkg::i2cm_item_t      item,
	input  wire logic [i2cm_pkg::TPU_W-1:0] tpu,
	output i2cm_pkg::i2cm_res_t            res_s2
);
	import i2cm_pkg::*;

	localparam logic [4:0] PH_IDLE      = 5'd0;
	localparam logic [4:0] PH_START_SDA = 5'd1;
	localparam logic [4:0] PH_STOP_SDA  = 5'd2;
	localparam logic [4:0] PH_STOP_SCL  = 5'd3;
	localparam logic [4:0] PH_W_SETUP   = 5'd4;
	localparam logic [4:0] PH_W_HIGH    = 5'd5;
	localparam logic [4:0] PH_W_LOW     = 5'd6;
	localparam logic [4:0] PH_W_REL     = 5'd7;
	localparam logic [4:0] PH_WA_GAP    = 5'd8;
	localparam logic [4:0] PH_WA_HIGH   = 5'd9;
	localparam logic [4:0] PH_WA_LOW    = 5'd10;
	localparam logic [4:0] PH_R_HIGH    = 5'd11;
	localparam logic [4:0] PH_R_LOW     = 5'd12;
	localparam logic [4:0] PH_A_DATA    = 5'd13;
	localparam logic [4:0] PH_A_HIGH    = 5'd14;

	logic [4:0]        phase_q, n_phase, tgt;
	logic [3:0]        bit_q, n_bit;
	logic [WAIT_W-1:0] wait_q, n_wait;
	logic [BYTE_W-1:0] shift_q, n_shift;
	logic [BYTE_W-1:0] read_q, n_read;
	logic [CMD_W-1:0]  cmd_q, n_cmd;
	logic              clk_lvl_q, n_clk_lvl;
	logic              dat_lvl_q, n_dat_lvl;
	logic              ack_q, n_ack;
	logic              do_enter, done;
	logic [3:0]        units;
	logic [TPU_W-1:0]  t_eff;

	assign t_eff = (tpu == '0) ? TPU_W'(1) : tpu;

	always_comb begin
		n_phase   = phase_q;
		n_bit     = bit_q;
		n_wait    = wait_q;
		n_shift   = shift_q;
		n_read    = read_q;
		n_cmd     = cmd_q;
		n_clk_lvl = clk_lvl_q;
		n_dat_lvl = dat_lvl_q;
		n_ack     = ack_q;
		do_enter  = 1'b0;
		tgt       = PH_IDLE;
		done      = 1'b0;
		units     = 4'd1;

		if (phase_q == PH_IDLE) begin
			if (item.command != CMD_NONE && item.command != CMD_RSVD) begin
				n_cmd    = item.command;
				n_bit    = '0;
				do_enter = 1'b1;
				case (item.command)
					CMD_START: tgt = PH_START_SDA;
					CMD_STOP:  tgt = PH_STOP_SDA;
					CMD_WRITE_ACK, CMD_WRITE: begin
						n_shift = item.write_data;
						tgt     = PH_W_SETUP;
					end
					default: begin
						n_shift = '0;
						tgt     = PH_R_HIGH;
					end
				endcase
			end
		end else if (wait_q != '0) begin
			n_wait = wait_q - WAIT_W'(1);
		end else begin
			case (phase_q)
				PH_START_SDA: begin
					n_clk_lvl = 1'b0;
					done      = 1'b1;
				end
				PH_STOP_SDA: begin
					do_enter = 1'b1;
					tgt      = PH_STOP_SCL;
				end
				PH_STOP_SCL: begin
					n_dat_lvl = 1'b1;
					done      = 1'b1;
				end
				PH_W_SETUP: begin
					do_enter = 1'b1;
					tgt      = PH_W_HIGH;
				end
				PH_W_HIGH: begin
					do_enter = 1'b1;
					tgt      = PH_W_LOW;
				end
				PH_W_LOW: begin
					do_enter = 1'b1;
					tgt      = PH_W_REL;
				end
				PH_W_REL: begin
					if (bit_q < 4'd7) begin
						n_bit    = bit_q + 4'd1;
						do_enter = 1'b1;
						tgt      = PH_W_SETUP;
					end else if (cmd_q == CMD_WRITE_ACK) begin
						do_enter = 1'b1;
						tgt      = PH_WA_GAP;
					end else begin
						done = 1'b1;
					end
				end
				PH_WA_GAP: begin
					do_enter = 1'b1;
					tgt      = PH_WA_HIGH;
				end
				PH_WA_HIGH: begin
					n_ack    = ~item.sda_in;
					do_enter = 1'b1;
					tgt      = PH_WA_LOW;
				end
				PH_WA_LOW: done = 1'b1;
				PH_R_HIGH: begin
					n_shift  = {shift_q[BYTE_W-2:0], item.sda_in};
					do_enter = 1'b1;
					tgt      = PH_R_LOW;
				end
				PH_R_LOW: begin
					do_enter = 1'b1;
					if (bit_q < 4'd7) begin
						n_bit = bit_q + 4'd1;
						tgt   = PH_R_HIGH;
					end else begin
						n_read = shift_q;
						tgt    = PH_A_DATA;
					end
				end
				PH_A_DATA: begin
					do_enter = 1'b1;
					tgt      = PH_A_HIGH;
				end
				PH_A_HIGH: begin
					n_clk_lvl = 1'b0;
					n_dat_lvl = 1'b1;
					done      = 1'b1;
				end
				default: begin
					n_phase = PH_IDLE;
					n_wait  = '0;
				end
			endcase
			if (done) begin
				n_phase = PH_IDLE;
				n_wait  = '0;
			end
		end

		// segment entry: set levels and load the hold count
		if (do_enter) begin
			n_phase = tgt;
			case (tgt)
				PH_START_SDA: n_dat_lvl = 1'b0;
				PH_STOP_SDA:  n_dat_lvl = 1'b0;
				PH_STOP_SCL:  n_clk_lvl = 1'b1;
				PH_W_SETUP:   n_dat_lvl = n_shift[3'd7 - n_bit[2:0]];
				PH_W_HIGH: begin
					n_clk_lvl = 1'b1;
					units     = 4'd3;
				end
				PH_W_LOW:     n_clk_lvl = 1'b0;
				PH_W_REL:     n_dat_lvl = 1'b1;
				PH_WA_GAP:    units = 4'd2;
				PH_WA_HIGH: begin
					n_clk_lvl = 1'b1;
					units     = 4'd10;
				end
				PH_WA_LOW: begin
					n_clk_lvl = 1'b0;
					units     = 4'd2;
				end
				PH_R_HIGH: begin
					n_clk_lvl = 1'b1;
					n_dat_lvl = 1'b1;
					units     = 4'd4;
				end
				PH_R_LOW: begin
					n_clk_lvl = 1'b0;
					units     = 4'd4;
				end
				PH_A_DATA: begin
					n_dat_lvl = (n_cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
					units     = 4'd2;
				end
				PH_A_HIGH: begin
					n_clk_lvl = 1'b1;
					units     = 4'd2;
				end
				default: n_phase = PH_IDLE;
			endcase
			n_wait = WAIT_W'(units) * WAIT_W'(t_eff) - WAIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= '0;
			wait_q    <= '0;
			shift_q   <= '0;
			read_q    <= '0;
			cmd_q     <= CMD_NONE;
			clk_lvl_q <= 1'b1;
			dat_lvl_q <= 1'b1;
			ack_q     <= 1'b0;
		end else if (en) begin
			phase_q   <= n_phase;
			bit_q     <= n_bit;
			wait_q    <= n_wait;
			shift_q   <= n_shift;
			read_q    <= n_read;
			cmd_q     <= n_cmd;
			clk_lvl_q <= n_clk_lvl;
			dat_lvl_q <= n_dat_lvl;
			ack_q     <= n_ack;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.scl       <= n_clk_lvl;
			res_s2.sda       <= n_dat_lvl;
			res_s2.busy      <= (n_phase != PH_IDLE);
			res_s2.done      <= done;
			res_s2.read_data <= n_read;
			res_s2.ack       <= n_ack;
		end
	end

	// idle never holds a pending count
	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> wait_q == '0)
		else $error("wait count nonzero while idle");

	// a counting segment keeps its phase
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		en && phase_q != PH_IDLE && wait_q != '0 |=> $stable(phase_q))
		else $error("phase moved while segment still counting");

	// no command leaves the sequencer idle
	a_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		en && phase_q == PH_IDLE && (item.command == CMD_NONE || item.command == CMD_RSVD)
		|=> phase_q == PH_IDLE)
		else $error("sequence started without a command");

	// state holds when no word is taken
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(phase_q) && $stable(wait_q) && $stable(bit_q))
		else $error("state changed without a word");

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// two-wire bus master bit engine driven, when not stalled, by one tick word per cycle
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid / in_stall): one word per bus timer tick with
//    command, write_data and the sampled sda_in level
//  - output channel (out_valid / out_stall): one result word per input word
//    with scl_out, sda_out, busy_res, done_res, read_data, ack_received
//  - cfg_we / cfg_data write ticks_per_delay_unit (0 acts as 1); write only
//    while no word is in flight
//  - commands are taken only when the sequencer is idle, else ignored
//  - path: an accepted word passes through the input register, then the
//    sequencer and result register, before its result is valid
//  - throughput: one word per cycle while the receiver does not stall; the sequencer update is a single pass
//  - reset: sequencer line levels high (result register not reset),
//    sequencer idle, both stages empty, tick count back to 100
//  - receiver stall: the result stage holds, and the input stage stalls
//    only once it is full behind it
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic [i2cm_pkg::TPU_W-1:0]  cfg_data,
	// tick words in
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [i2cm_pkg::CMD_W-1:0]  command,
	input  wire logic [i2cm_pkg::BYTE_W-1:0] write_data,
	input  wire logic                        sda_in,
	// results out
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             scl_out,
	output logic                             sda_out,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [i2cm_pkg::BYTE_W-1:0]      read_data,
	output logic                             ack_received
);
	import i2cm_pkg::*;

	logic [TPU_W-1:0] tpu_q;
	logic             valid_s1, valid_s2;
	i2cm_item_t       item_s1;
	i2cm_res_t        res_s2;
	logic             hold_s2;   // result stage blocked by the receiver
	logic             adv_s1;    // stage 1 word moves into the sequencer
	logic             take_in;   // input word accepted

	// tick count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_we) begin
			tpu_q <= cfg_data;
		end
	end

	// pipeline control
	assign hold_s2  = valid_s2 && out_stall;
	assign adv_s1   = valid_s1 && !hold_s2;
	assign in_stall = valid_s1 && hold_s2;
	assign take_in  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.command    <= command;
			item_s1.write_data <= write_data;
			item_s1.sda_in     <= sda_in;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!hold_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// sequencer with result register
	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.tpu    (tpu_q),
		.res_s2 (res_s2)
	);

	assign out_valid    = valid_s2;
	assign scl_out      = res_s2.scl;
	assign sda_out      = res_s2.sda;
	assign busy_res     = res_s2.busy;
	assign done_res     = res_s2.done;
	assign read_data    = res_s2.read_data;
	assign ack_received = res_s2.ack;

endmodule

`default_nettype wire
